/* sv/status_led_priority_timer_core_defines.svh */
// Assertion macros for the status LED priority timer core.
// Used by the top level only; needs clk and arst_n in scope.
`ifndef STATUS_LED_PRIORITY_TIMER_CORE_DEFINES_SVH
`define STATUS_LED_PRIORITY_TIMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SLTC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sltc check failed");
`define SLTC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sltc check failed");
`else
`define SLTC_ASSERT_IMP(label, ante, cons)
`define SLTC_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* sv/sltc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants for the status LED priority timer.
// No dependencies.
package sltc_pkg;

	localparam int AGE_W = 16;
	localparam logic [AGE_W-1:0] AGE_MAX = '1;
	localparam logic [7:0] LED_ON = 8'd255;
	localparam logic [7:0] LED_OFF = 8'd0;

	localparam int IN_BYTES_W = 8;
	localparam int OUT_BYTES_W = 32;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [AGE_W-1:0] CONN_TIMEOUT_RST = 16'd1000;
	localparam logic [AGE_W-1:0] ERR_HOLD_RST = 16'd1000;
	localparam logic [AGE_W-1:0] SAVE_HOLD_RST = 16'd500;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_CONN_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_ERR_HOLD = 2'd1;
	localparam logic [1:0] REG_SAVE_HOLD = 2'd2;

	typedef enum logic [2:0] {
		CMD_TICK = 3'd0,
		CMD_BEGIN = 3'd1,
		CMD_END_BOOT = 3'd2,
		CMD_ACTIVITY = 3'd3,
		CMD_SET_UNSAVED = 3'd4,
		CMD_SET_SAVING = 3'd5,
		CMD_ERROR = 3'd6,
		CMD_UPDATE = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_BOOT = 3'd0,
		ST_NORMAL = 3'd1,
		ST_CONNECTED = 3'd2,
		ST_UNSAVED = 3'd3,
		ST_SAVING = 3'd4,
		ST_ERROR = 3'd5
	} disp_t;

	// packed from the top bit down, so command sits in the lowest bits
	typedef struct packed {
		logic led_ready;
		logic led_init_ok;
		logic flag_value;
		cmd_t command;
	} in_item_t;

	typedef struct packed {
		logic ready_for_command;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic write_strobe;
		disp_t shown_state;
	} out_item_t;

	typedef struct packed {
		logic [AGE_W-1:0] connected_timeout_ms;
		logic [AGE_W-1:0] error_hold_ms;
		logic [AGE_W-1:0] saving_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
	} rgb_t;

	function automatic rgb_t state_color(input disp_t st);
		rgb_t c;
		c = '{b: LED_OFF, g: LED_OFF, r: LED_OFF};
		case (st)
			ST_BOOT: begin
				c = '{b: LED_ON, g: LED_ON, r: LED_ON};
			end
			ST_NORMAL: begin
				c.b = LED_ON;
			end
			ST_CONNECTED: begin
				c.g = LED_ON;
			end
			ST_UNSAVED: begin
				c.r = LED_ON;
				c.g = LED_ON;
			end
			ST_SAVING: begin
				c.r = LED_ON;
				c.b = LED_ON;
			end
			default: begin
				c.r = LED_ON;
			end
		endcase
		return c;
	endfunction

	function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
		return (a == AGE_MAX) ? a : a + 1'b1;
	endfunction

endpackage

/* sv/sltc_regs.sv */
`timescale 1ns / 1ps
// Configuration registers behind an APB-style port: timeouts and hold limits.
// Depends on sltc_pkg.
module sltc_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sltc_pkg::ADDR_W-1:0] paddr,
	input  logic [sltc_pkg::DATA_W-1:0] pwdata,
	output logic [sltc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output sltc_pkg::cfg_t              cfg
);
	import sltc_pkg::*;

	cfg_t cfg_q;
	logic wr_en;
	logic [1:0] reg_idx;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.connected_timeout_ms <= CONN_TIMEOUT_RST;
			cfg_q.error_hold_ms <= ERR_HOLD_RST;
			cfg_q.saving_hold_ms <= SAVE_HOLD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CONN_TIMEOUT: cfg_q.connected_timeout_ms <= pwdata[AGE_W-1:0];
				REG_ERR_HOLD: cfg_q.error_hold_ms <= pwdata[AGE_W-1:0];
				REG_SAVE_HOLD: cfg_q.saving_hold_ms <= pwdata[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CONN_TIMEOUT: prdata = {{(DATA_W-AGE_W){1'b0}}, cfg_q.connected_timeout_ms};
			REG_ERR_HOLD: prdata = {{(DATA_W-AGE_W){1'b0}}, cfg_q.error_hold_ms};
			REG_SAVE_HOLD: prdata = {{(DATA_W-AGE_W){1'b0}}, cfg_q.saving_hold_ms};
			default: prdata = '0;
		endcase
	end

endmodule

/* sv/sltc_engine.sv */
`timescale 1ns / 1ps
// Status flags, hold counters and priority pick for one request per cycle while step is high.
// Depends on sltc_pkg.
module sltc_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  sltc_pkg::in_item_t  item,
	input  sltc_pkg::cfg_t      cfg,
	output sltc_pkg::out_item_t result
);
	import sltc_pkg::*;

	logic in_boot_q, link_active_q, has_unsaved_q, is_saving_q;
	logic saving_held_q, error_held_q, led_usable_q, has_shown_q;
	disp_t last_shown_q;
	logic [AGE_W-1:0] activity_age_q, error_age_q, saving_age_q;

	logic in_boot_n, link_active_n, has_unsaved_n, is_saving_n;
	logic saving_held_n, error_held_n, led_usable_n, has_shown_n;
	disp_t last_shown_n, st;
	logic [AGE_W-1:0] activity_age_n, error_age_n, saving_age_n;
	logic try_write, do_write;
	rgb_t color;

	always_comb begin
		in_boot_n = in_boot_q;
		link_active_n = link_active_q;
		has_unsaved_n = has_unsaved_q;
		is_saving_n = is_saving_q;
		saving_held_n = saving_held_q;
		error_held_n = error_held_q;
		led_usable_n = led_usable_q;
		has_shown_n = has_shown_q;
		activity_age_n = activity_age_q;
		error_age_n = error_age_q;
		saving_age_n = saving_age_q;
		try_write = 1'b0;

		case (item.command)
			CMD_TICK: begin
				activity_age_n = age_inc(activity_age_q);
				error_age_n = age_inc(error_age_q);
				saving_age_n = age_inc(saving_age_q);
			end
			CMD_BEGIN: begin
				in_boot_n = 1'b1;
				link_active_n = 1'b0;
				has_unsaved_n = 1'b0;
				is_saving_n = 1'b0;
				saving_held_n = 1'b0;
				error_held_n = 1'b0;
				has_shown_n = 1'b0;
				led_usable_n = item.led_init_ok;
				try_write = 1'b1;
			end
			CMD_END_BOOT: begin
				in_boot_n = 1'b0;
				try_write = 1'b1;
			end
			CMD_ACTIVITY: begin
				link_active_n = 1'b1;
				activity_age_n = '0;
			end
			CMD_SET_UNSAVED: begin
				has_unsaved_n = item.flag_value;
			end
			CMD_SET_SAVING: begin
				is_saving_n = item.flag_value;
				if (item.flag_value) begin
					saving_held_n = 1'b1;
					saving_age_n = '0;
				end
				try_write = 1'b1;
			end
			CMD_ERROR: begin
				error_held_n = 1'b1;
				error_age_n = '0;
			end
			default: begin
				try_write = 1'b1;
			end
		endcase

		// drop holds whose age reached the limit
		if (activity_age_n >= cfg.connected_timeout_ms) link_active_n = 1'b0;
		if (error_age_n >= cfg.error_hold_ms) error_held_n = 1'b0;
		if (saving_age_n >= cfg.saving_hold_ms) saving_held_n = 1'b0;

		if (in_boot_n) st = ST_BOOT;
		else if (error_held_n) st = ST_ERROR;
		else if (is_saving_n || saving_held_n) st = ST_SAVING;
		else if (has_unsaved_n) st = ST_UNSAVED;
		else if (link_active_n) st = ST_CONNECTED;
		else st = ST_NORMAL;

		do_write = try_write && led_usable_n && !(has_shown_n && st == last_shown_q)
			&& !(has_shown_n && !item.led_ready);

		last_shown_n = last_shown_q;
		color = '{b: LED_OFF, g: LED_OFF, r: LED_OFF};
		if (do_write) begin
			color = state_color(st);
			last_shown_n = st;
			has_shown_n = 1'b1;
		end

		result.shown_state = st;
		result.write_strobe = do_write;
		result.red = color.r;
		result.green = color.g;
		result.blue = color.b;
		result.ready_for_command = !led_usable_n || item.led_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_boot_q <= 1'b1;
			link_active_q <= 1'b0;
			has_unsaved_q <= 1'b0;
			is_saving_q <= 1'b0;
			saving_held_q <= 1'b0;
			error_held_q <= 1'b0;
			led_usable_q <= 1'b0;
			has_shown_q <= 1'b0;
			last_shown_q <= ST_BOOT;
			activity_age_q <= '0;
			error_age_q <= '0;
			saving_age_q <= '0;
		end else if (step) begin
			in_boot_q <= in_boot_n;
			link_active_q <= link_active_n;
			has_unsaved_q <= has_unsaved_n;
			is_saving_q <= is_saving_n;
			saving_held_q <= saving_held_n;
			error_held_q <= error_held_n;
			led_usable_q <= led_usable_n;
			has_shown_q <= has_shown_n;
			last_shown_q <= last_shown_n;
			activity_age_q <= activity_age_n;
			error_age_q <= error_age_n;
			saving_age_q <= saving_age_n;
		end
	end

endmodule

/* sv/status_led_priority_timer_core.sv */
`timescale 1ns / 1ps
// Status LED priority timer core: input register, one-pass state update, result register.
// A taken request is registered in the input register and its result in the result register.
// Throughput: one request per cycle while m_tready is high; s_tready stays high while the
// result register drains. Reset (arst_n low, asynchronous): both stages empty, flags and ages
// cleared, in_boot set, timeouts back to 1000/1000/500 ms.
module status_led_priority_timer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [sltc_pkg::IN_BYTES_W-1:0]  s_tdata,   // command[2:0], flag_value[3],
	                                                    // led_init_ok[4], led_ready[5]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [sltc_pkg::OUT_BYTES_W-1:0] m_tdata,   // shown_state[2:0], write_strobe[3],
	                                                    // red[11:4], green[19:12],
	                                                    // blue[27:20], ready_for_command[28]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sltc_pkg::*;

	`include "status_led_priority_timer_core_defines.svh"

	cfg_t cfg;
	in_item_t item_s1;
	logic valid_s1;
	out_item_t result, out_s2;
	logic valid_s2;
	logic advance;

	sltc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	sltc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance && valid_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign advance = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata = {{(OUT_BYTES_W-$bits(out_item_t)){1'b0}}, out_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) item_s1 <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
		if (advance && valid_s1) out_s2 <= result;
	end

	`SLTC_ASSERT_IMP(a_rgb_zero_no_write, m_tvalid && !m_tdata[3], m_tdata[27:4] == 24'd0)
	`SLTC_ASSERT_IMP(a_rgb_lit_on_write, m_tvalid && m_tdata[3], m_tdata[27:4] != 24'd0)
	`SLTC_ASSERT_IMP(a_state_range, m_tvalid, m_tdata[2:0] <= 3'd5)
	`SLTC_ASSERT_IMP(a_ready_when_drained, !m_tvalid, s_tready)
	`SLTC_ASSERT_NXT(a_result_follows, valid_s1 && advance, m_tvalid)

endmodule

/* test/status_led_priority_timer_core_test.sv */
`timescale 1ns / 1ps
// Self-checking test for status_led_priority_timer_core: stream requests and results are
// checked against a cycle-free predictor of the flags, hold timers and colour writes.
// Depends on sltc_pkg for the command, display state and item types.
module status_led_priority_timer_core_test;
	import sltc_pkg::*;

	localparam int CLK_HALF_NS = 10;
	localparam int RESET_CYCLES = 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam logic [15:0] LIMIT_MAX = 16'hFFFF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // command[2:0], flag_value[3], led_init_ok[4], led_ready[5]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // shown_state[2:0], write_strobe[3], red[11:4],
	                               // green[19:12], blue[27:20], ready_for_command[28]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	status_led_priority_timer_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#CLK_HALF_NS clk = 1'b1;
		#CLK_HALF_NS clk = 1'b0;
	end

	// predicted block state
	logic [15:0] lim_link = CONN_TIMEOUT_RST;
	logic [15:0] lim_err = ERR_HOLD_RST;
	logic [15:0] lim_save = SAVE_HOLD_RST;
	bit          boot_f = 1'b1;
	bit          link_f, unsaved_f, saving_f, save_hold_f, err_hold_f, usable_f, shown_f;
	disp_t       last_disp = ST_BOOT;
	logic [15:0] link_age = '0;
	logic [15:0] err_age = '0;
	logic [15:0] save_age = '0;

	in_item_t    pending_requests[$];
	out_item_t   expected_leds[$];
	int          requests_pushed = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          src_idle_pct = 0;
	int          sink_idle_pct = 0;
	int          src_gap = 0;
	int          sink_gap = 0;
	bit          req_taken = 1'b0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d, expected %0d at %0t ns", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic logic [15:0] bump_age(input logic [15:0] a);
		return (a == LIMIT_MAX) ? a : a + 16'd1;
	endfunction

	task automatic predict_led_result(input in_item_t req);
		disp_t     st;
		bit        want_write;
		out_item_t res;
		want_write = 1'b0;
		case (req.command)
			CMD_TICK: begin
				link_age = bump_age(link_age);
				err_age = bump_age(err_age);
				save_age = bump_age(save_age);
			end
			CMD_BEGIN: begin
				boot_f = 1'b1;
				{link_f, unsaved_f, saving_f, save_hold_f, err_hold_f, shown_f} = '0;
				usable_f = req.led_init_ok;
				want_write = 1'b1;
			end
			CMD_END_BOOT: begin
				boot_f = 1'b0;
				want_write = 1'b1;
			end
			CMD_ACTIVITY: begin
				link_f = 1'b1;
				link_age = '0;
			end
			CMD_SET_UNSAVED: begin
				unsaved_f = req.flag_value;
			end
			CMD_SET_SAVING: begin
				saving_f = req.flag_value;
				if (req.flag_value) begin
					save_hold_f = 1'b1;
					save_age = '0;
				end
				want_write = 1'b1;
			end
			CMD_ERROR: begin
				err_hold_f = 1'b1;
				err_age = '0;
			end
			default: begin
				want_write = 1'b1;
			end
		endcase
		// expire holds after every request, so a zero limit clears at once
		if (link_f && link_age >= lim_link) link_f = 1'b0;
		if (err_hold_f && err_age >= lim_err) err_hold_f = 1'b0;
		if (save_hold_f && save_age >= lim_save) save_hold_f = 1'b0;
		if (boot_f) st = ST_BOOT;
		else if (err_hold_f) st = ST_ERROR;
		else if (saving_f || save_hold_f) st = ST_SAVING;
		else if (unsaved_f) st = ST_UNSAVED;
		else if (link_f) st = ST_CONNECTED;
		else st = ST_NORMAL;
		res = '0;
		res.shown_state = st;
		res.ready_for_command = !usable_f || req.led_ready;
		if (want_write && usable_f && !(shown_f && st == last_disp) &&
				!(shown_f && !req.led_ready)) begin
			res.write_strobe = 1'b1;
			res.red = (st == ST_BOOT || st == ST_UNSAVED || st == ST_SAVING ||
				st == ST_ERROR) ? LED_ON : LED_OFF;
			res.green = (st == ST_BOOT || st == ST_CONNECTED || st == ST_UNSAVED) ?
				LED_ON : LED_OFF;
			res.blue = (st == ST_BOOT || st == ST_NORMAL || st == ST_SAVING) ?
				LED_ON : LED_OFF;
			last_disp = st;
			shown_f = 1'b1;
		end
		expected_leds.push_back(res);
	endtask

	// request side: hold until taken, then idle or present the next one
	always @(negedge clk) begin
		if (req_taken || !s_tvalid) begin
			req_taken = 1'b0;
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
				src_gap = $urandom_range(18, 0);
				s_tvalid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				s_tdata <= {2'b00, pending_requests.pop_front()};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (sink_gap > 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
			sink_gap = $urandom_range(18, 0);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (s_tvalid && s_tready) begin
			req_taken = 1'b1;
			predict_led_result(in_item_t'(s_tdata[5:0]));
		end
		if (m_tvalid && m_tready) begin
			got = out_item_t'(m_tdata[28:0]);
			if (expected_leds.size() == 0) begin
				report_mismatch("result with nothing pending", int'(m_tdata), 0);
			end else begin
				want = expected_leds.pop_front();
				if (got.shown_state !== want.shown_state)
					report_mismatch("shown_state", got.shown_state, want.shown_state);
				if (got.write_strobe !== want.write_strobe)
					report_mismatch("write_strobe", got.write_strobe, want.write_strobe);
				if (got.red !== want.red) report_mismatch("red", got.red, want.red);
				if (got.green !== want.green) report_mismatch("green", got.green, want.green);
				if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
				if (got.ready_for_command !== want.ready_for_command)
					report_mismatch("ready_for_command", got.ready_for_command,
						want.ready_for_command);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic apb_access(input logic [1:0] idx, input bit wr, input logic [15:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, wdata};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_register(input logic [1:0] idx, input logic [15:0] want);
		logic [31:0] rd;
		apb_access(idx, 1'b0, 16'd0, rd);
		if (rd[15:0] !== want) report_mismatch("register readback", rd[15:0], want);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
		logic [31:0] rd;
		apb_access(idx, 1'b1, val, rd);
		check_register(idx, val);
	endtask

	task automatic program_limits(input logic [15:0] c, input logic [15:0] e,
			input logic [15:0] s);
		write_register(REG_CONN_TIMEOUT, c);
		lim_link = c;
		write_register(REG_ERR_HOLD, e);
		lim_err = e;
		write_register(REG_SAVE_HOLD, s);
		lim_save = s;
	endtask

	task automatic push_request(input cmd_t cmd, input bit fv, input bit ok, input bit rdy);
		in_item_t r;
		r.command = cmd;
		r.flag_value = fv;
		r.led_init_ok = ok;
		r.led_ready = rdy;
		pending_requests.push_back(r);
		requests_pushed++;
	endtask

	function automatic int pick_idle_pct();
		case ($urandom_range(3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	task automatic push_random(input int n);
		int pick;
		cmd_t cmd;
		// start from a usable LED out of boot so the later states are reached
		push_request(CMD_BEGIN, 1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)));
		push_request(CMD_END_BOOT, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1);
		repeat (n) begin
			pick = $urandom_range(99);
			if (pick < 38) cmd = CMD_TICK;
			else if (pick < 41) cmd = CMD_BEGIN;
			else if (pick < 47) cmd = CMD_END_BOOT;
			else if (pick < 57) cmd = CMD_ACTIVITY;
			else if (pick < 65) cmd = CMD_SET_UNSAVED;
			else if (pick < 75) cmd = CMD_SET_SAVING;
			else if (pick < 82) cmd = CMD_ERROR;
			else if (pick < 92) cmd = CMD_UPDATE;
			else cmd = cmd_t'($urandom_range(7));
			push_request(cmd, 1'($urandom_range(1)), $urandom_range(9) != 0,
				$urandom_range(9) < 7);
		end
	endtask

	task automatic drain_results();
		while (results_seen != requests_pushed) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int pct;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		check_register(REG_CONN_TIMEOUT, CONN_TIMEOUT_RST);
		check_register(REG_ERR_HOLD, ERR_HOLD_RST);
		check_register(REG_SAVE_HOLD, SAVE_HOLD_RST);

		// directed: no write before begin, first write ignores ready, expiry, zero limit
		program_limits(16'd2, 16'd0, 16'd1);
		src_idle_pct = 30;
		sink_idle_pct = 30;
		push_request(CMD_UPDATE, 1'b0, 1'b1, 1'b1);
		push_request(CMD_END_BOOT, 1'b0, 1'b0, 1'b1);
		push_request(CMD_TICK, 1'b1, 1'b1, 1'b1);
		push_request(CMD_BEGIN, 1'b0, 1'b1, 1'b0);
		push_request(CMD_UPDATE, 1'b0, 1'b0, 1'b1);
		push_request(CMD_END_BOOT, 1'b0, 1'b0, 1'b0);
		push_request(CMD_END_BOOT, 1'b0, 1'b0, 1'b1);
		push_request(CMD_ACTIVITY, 1'b0, 1'b0, 1'b1);
		push_request(CMD_UPDATE, 1'b0, 1'b0, 1'b1);
		push_request(CMD_TICK, 1'b0, 1'b0, 1'b1);
		push_request(CMD_TICK, 1'b0, 1'b0, 1'b1);
		push_request(CMD_UPDATE, 1'b0, 1'b0, 1'b1);
		push_request(CMD_ERROR, 1'b0, 1'b0, 1'b1);
		push_request(CMD_SET_UNSAVED, 1'b1, 1'b0, 1'b1);
		push_request(CMD_UPDATE, 1'b0, 1'b0, 1'b1);
		push_request(CMD_SET_SAVING, 1'b1, 1'b0, 1'b1);
		push_request(CMD_SET_SAVING, 1'b0, 1'b0, 1'b1);
		push_request(CMD_TICK, 1'b0, 1'b0, 1'b1);
		push_request(CMD_UPDATE, 1'b0, 1'b0, 1'b1);
		push_request(CMD_SET_UNSAVED, 1'b0, 1'b0, 1'b0);
		push_request(CMD_BEGIN, 1'b0, 1'b0, 1'b0);
		push_request(CMD_UPDATE, 1'b0, 1'b0, 1'b0);
		push_request(CMD_BEGIN, 1'b0, 1'b1, 1'b1);
		push_request(CMD_END_BOOT, 1'b0, 1'b1, 1'b1);
		drain_results();

		// reset limits restored, then both extremes
		program_limits(CONN_TIMEOUT_RST, ERR_HOLD_RST, SAVE_HOLD_RST);
		pct = pick_idle_pct();
		src_idle_pct = pct;
		sink_idle_pct = pick_idle_pct();
		push_random(150);
		drain_results();

		program_limits(16'd0, 16'd0, 16'd0);
		src_idle_pct = pick_idle_pct();
		sink_idle_pct = pick_idle_pct();
		push_random(200);
		drain_results();

		program_limits(LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
		src_idle_pct = pick_idle_pct();
		sink_idle_pct = pick_idle_pct();
		push_random(200);
		drain_results();

		repeat (5) begin
			if ($urandom_range(3) == 0)
				program_limits(16'($urandom_range(65535)), 16'($urandom_range(65535)),
					16'($urandom_range(65535)));
			else
				program_limits(16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)),
					16'($urandom_range(40, 1)));
			src_idle_pct = pick_idle_pct();
			sink_idle_pct = pick_idle_pct();
			push_random(200);
			drain_results();
		end

		// closing stretch at full rate
		program_limits(16'($urandom_range(12, 1)), 16'($urandom_range(12, 1)),
			16'($urandom_range(12, 1)));
		src_idle_pct = 0;
		sink_idle_pct = 0;
		push_random(150);
		drain_results();

		if (expected_leds.size() != 0)
			report_mismatch("results still pending", expected_leds.size(), 0);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
